// ===== rtl/mos_pkg.sv =====
// ----------------------------------------------------------------------------
// mos_pkg: shared types and constants of the 6502 execute unit
// Holds the architectural register bundle, reset values and flag positions.
// ----------------------------------------------------------------------------
package mos_pkg;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
	} arch_t;

	// One executed item: up to three writes and the final register image.
	typedef struct packed {
		logic [1:0]  nwr;
		logic [2:0][15:0] waddr;
		logic [2:0][7:0]  wdata;
		arch_t       regs;
		logic        bad;
	} exec_t;

	localparam logic [7:0]  SP_RESET   = 8'hFD;
	localparam logic [7:0]  P_RESET    = 8'h24;
	localparam logic [15:0] STACK_PAGE = 16'h0100;
	localparam logic [7:0]  PULL_MASK  = 8'hCF;
	localparam logic [7:0]  KEEP_MASK  = 8'h30;

	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic REQ_NMI = 1'b1;

endpackage

// ===== rtl/mos6502_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mos6502_execute_unit: 6502 execute stage without decimal mode
//
//  channel  | handshake             | payload
//  in       | in_valid / in_ready   | req_type, opcode, operand, eff_addr, ...
//  out      | out_valid / out_ready | write_*, out_*, bad_opcode, last_of_run
//
// An item is evaluated in one pass as it is accepted and its results leave
// one per cycle while out_ready is high: its writes, then the register result.
// The next item is taken in the cycle its final result goes.
// Reset loads A, X, Y = 0, SP = 0xFD, P = 0x24, PC = 0.
// A stalled output holds the current result and blocks new items.
// ----------------------------------------------------------------------------
module mos6502_execute_unit import mos_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand,
	input  logic [15:0] eff_addr,
	input  logic [15:0] next_pc,
	input  logic [7:0]  pull_first,
	input  logic [7:0]  pull_second,
	input  logic [7:0]  pull_third,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [15:0] write_addr,
	output logic [7:0]  write_data,
	output logic [7:0]  out_a,
	output logic [7:0]  out_x,
	output logic [7:0]  out_y,
	output logic [7:0]  out_sp,
	output logic [7:0]  out_status,
	output logic [15:0] out_pc,
	output logic        bad_opcode,
	output logic        last_of_run
);

	arch_t arch_q;
	exec_t exec;
	logic  busy;
	logic  done;
	logic  load;

	assign in_ready  = !busy || done;
	assign load      = in_valid && in_ready;
	assign out_valid = busy;

	mos_alu u_alu (
		.req_type(req_type), .opcode(opcode), .operand(operand),
		.eff_addr(eff_addr), .next_pc(next_pc), .pull_first(pull_first),
		.pull_second(pull_second), .pull_third(pull_third),
		.cur(arch_q), .res(exec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: P_RESET,
				pc: 16'h0000};
		end else if (load) begin
			arch_q <= exec.regs;
		end
	end

	mos_out_seq u_seq (
		.clk(clk), .arst_n(arst_n), .load(load), .item(exec),
		.busy(busy), .done(done), .ready(out_ready),
		.write_valid(write_valid), .write_addr(write_addr), .write_data(write_data),
		.out_a(out_a), .out_x(out_x), .out_y(out_y), .out_sp(out_sp),
		.out_status(out_status), .out_pc(out_pc), .bad_opcode(bad_opcode),
		.last_of_run(last_of_run)
	);

endmodule

// ===== rtl/mos_alu.sv =====
// ----------------------------------------------------------------------------
// mos_alu: single-pass instruction evaluation
// Computes the writes and the next register image of one item.
// ----------------------------------------------------------------------------
module mos_alu import mos_pkg::*; (
	input  logic        req_type,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand,
	input  logic [15:0] eff_addr,
	input  logic [15:0] next_pc,
	input  logic [7:0]  pull_first,
	input  logic [7:0]  pull_second,
	input  logic [7:0]  pull_third,
	input  arch_t       cur,
	output exec_t       res
);

	arch_t       r;
	logic [7:0]  t;
	logic [8:0]  sum;
	logic [7:0]  adc_m;
	logic        do_adc;
	logic        take;
	logic        br;
	logic [15:0] ret;
	logic [2:0]  cc;
	logic [2:0]  aaa;

	function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] q;
		q = p;
		q[FLAG_Z] = (v == 8'h00);
		q[FLAG_N] = v[7];
		return q;
	endfunction

	always_comb begin
		r = cur;
		r.pc = next_pc;
		res = '0;
		t = '0;
		adc_m = '0;
		do_adc = 1'b0;
		br = 1'b0;
		take = 1'b0;
		ret = next_pc - 16'd1;
		cc = opcode[2:0];
		aaa = opcode[7:5];
		if (req_type == REQ_NMI) begin
			res.nwr = 2'd3;
			res.waddr[0] = STACK_PAGE | {8'h00, cur.sp};
			res.wdata[0] = next_pc[15:8];
			res.waddr[1] = STACK_PAGE | {8'h00, 8'(cur.sp - 8'd1)};
			res.wdata[1] = next_pc[7:0];
			res.waddr[2] = STACK_PAGE | {8'h00, 8'(cur.sp - 8'd2)};
			res.wdata[2] = (cur.p | 8'h20) & 8'hEF;
			r.sp = cur.sp - 8'd3;
			r.p[FLAG_I] = 1'b1;
			r.pc = eff_addr;
		end else begin
			case (opcode)
				8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: begin
					r.a = cur.a | operand; r.p = nz(cur.p, r.a);
				end
				8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: begin
					r.a = cur.a & operand; r.p = nz(cur.p, r.a);
				end
				8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: begin
					r.a = cur.a ^ operand; r.p = nz(cur.p, r.a);
				end
				8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: begin
					do_adc = 1'b1; adc_m = operand;
				end
				8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD, 8'hEB: begin
					do_adc = 1'b1; adc_m = ~operand;
				end
				8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: begin
					r.p = nz(cur.p, 8'(cur.a - operand)); r.p[FLAG_C] = cur.a >= operand;
				end
				8'hE0, 8'hE4, 8'hEC: begin
					r.p = nz(cur.p, 8'(cur.x - operand)); r.p[FLAG_C] = cur.x >= operand;
				end
				8'hC0, 8'hC4, 8'hCC: begin
					r.p = nz(cur.p, 8'(cur.y - operand)); r.p[FLAG_C] = cur.y >= operand;
				end
				8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: begin
					r.a = operand; r.p = nz(cur.p, operand);
				end
				8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
					r.x = operand; r.p = nz(cur.p, operand);
				end
				8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
					r.y = operand; r.p = nz(cur.p, operand);
				end
				8'hA3, 8'hA7, 8'hAF, 8'hB3, 8'hB7, 8'hBF: begin
					r.a = operand; r.x = operand; r.p = nz(cur.p, operand);
				end
				8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = cur.a;
				end
				8'h86, 8'h8E, 8'h96: begin
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = cur.x;
				end
				8'h84, 8'h8C, 8'h94: begin
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = cur.y;
				end
				8'h83, 8'h87, 8'h8F, 8'h97: begin
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = cur.a & cur.x;
				end
				8'h0A, 8'h2A, 8'h4A, 8'h6A,
				8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
				8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E,
				8'h03, 8'h07, 8'h0F, 8'h13, 8'h17, 8'h1B, 8'h1F,
				8'h23, 8'h27, 8'h2F, 8'h33, 8'h37, 8'h3B, 8'h3F,
				8'h43, 8'h47, 8'h4F, 8'h53, 8'h57, 8'h5B, 8'h5F,
				8'h63, 8'h67, 8'h6F, 8'h73, 8'h77, 8'h7B, 8'h7F: begin
					// Shift kind comes from bits 6:5: ASL, ROL, LSR, ROR.
					if (!aaa[1]) begin
						t = {operand[6:0], aaa[0] & cur.p[FLAG_C]};
						r.p[FLAG_C] = operand[7];
					end else begin
						t = {aaa[0] & cur.p[FLAG_C], operand[7:1]};
						r.p[FLAG_C] = operand[0];
					end
					if (opcode[3:0] == 4'hA) begin
						r.a = t; r.p = nz(r.p, t);
					end else begin
						res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = t;
						if (!cc[0] || cc == 3'd6) begin
							r.p = nz(r.p, t);
						end else begin
							case (aaa[1:0])
								2'd0: begin r.a = cur.a | t; r.p = nz(r.p, r.a); end
								2'd1: begin r.a = cur.a & t; r.p = nz(r.p, r.a); end
								2'd2: begin r.a = cur.a ^ t; r.p = nz(r.p, r.a); end
								default: begin do_adc = 1'b1; adc_m = t; end
							endcase
						end
					end
				end
				8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
					t = operand + 8'd1;
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = t;
					r.p = nz(cur.p, t);
				end
				8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
					t = operand - 8'd1;
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = t;
					r.p = nz(cur.p, t);
				end
				8'hC3, 8'hC7, 8'hCF, 8'hD3, 8'hD7, 8'hDB, 8'hDF: begin
					t = operand - 8'd1;
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = t;
					r.p = nz(cur.p, 8'(cur.a - t)); r.p[FLAG_C] = cur.a >= t;
				end
				8'hE3, 8'hE7, 8'hEF, 8'hF3, 8'hF7, 8'hFB, 8'hFF: begin
					t = operand + 8'd1;
					res.nwr = 2'd1; res.waddr[0] = eff_addr; res.wdata[0] = t;
					do_adc = 1'b1; adc_m = ~t;
				end
				8'h24, 8'h2C: begin
					r.p[FLAG_N] = operand[7];
					r.p[FLAG_V] = operand[6];
					r.p[FLAG_Z] = (cur.a & operand) == 8'h00;
				end
				8'h4C, 8'h6C: r.pc = eff_addr;
				8'h20: begin
					res.nwr = 2'd2;
					res.waddr[0] = STACK_PAGE | {8'h00, cur.sp};
					res.wdata[0] = ret[15:8];
					res.waddr[1] = STACK_PAGE | {8'h00, 8'(cur.sp - 8'd1)};
					res.wdata[1] = ret[7:0];
					r.sp = cur.sp - 8'd2;
					r.pc = eff_addr;
				end
				8'h60: begin
					r.sp = cur.sp + 8'd2;
					r.pc = {pull_second, pull_first} + 16'd1;
				end
				8'h40: begin
					r.sp = cur.sp + 8'd3;
					r.p = (cur.p & KEEP_MASK) | (pull_first & PULL_MASK);
					r.pc = {pull_third, pull_second};
				end
				8'h08: begin
					res.nwr = 2'd1; res.waddr[0] = STACK_PAGE | {8'h00, cur.sp};
					res.wdata[0] = cur.p | 8'h30; r.sp = cur.sp - 8'd1;
				end
				8'h48: begin
					res.nwr = 2'd1; res.waddr[0] = STACK_PAGE | {8'h00, cur.sp};
					res.wdata[0] = cur.a; r.sp = cur.sp - 8'd1;
				end
				8'h28: begin
					r.sp = cur.sp + 8'd1;
					r.p = (cur.p & KEEP_MASK) | (pull_first & PULL_MASK);
				end
				8'h68: begin
					r.sp = cur.sp + 8'd1; r.a = pull_first; r.p = nz(cur.p, pull_first);
				end
				8'h10: begin br = 1'b1; take = !cur.p[FLAG_N]; end
				8'h30: begin br = 1'b1; take = cur.p[FLAG_N]; end
				8'h50: begin br = 1'b1; take = !cur.p[FLAG_V]; end
				8'h70: begin br = 1'b1; take = cur.p[FLAG_V]; end
				8'h90: begin br = 1'b1; take = !cur.p[FLAG_C]; end
				8'hB0: begin br = 1'b1; take = cur.p[FLAG_C]; end
				8'hD0: begin br = 1'b1; take = !cur.p[FLAG_Z]; end
				8'hF0: begin br = 1'b1; take = cur.p[FLAG_Z]; end
				8'h18: r.p[FLAG_C] = 1'b0;
				8'h38: r.p[FLAG_C] = 1'b1;
				8'h58: r.p[FLAG_I] = 1'b0;
				8'h78: r.p[FLAG_I] = 1'b1;
				8'hB8: r.p[FLAG_V] = 1'b0;
				8'hD8: r.p[FLAG_D] = 1'b0;
				8'hF8: r.p[FLAG_D] = 1'b1;
				8'hAA: begin r.x = cur.a; r.p = nz(cur.p, cur.a); end
				8'hA8: begin r.y = cur.a; r.p = nz(cur.p, cur.a); end
				8'hBA: begin r.x = cur.sp; r.p = nz(cur.p, cur.sp); end
				8'h8A: begin r.a = cur.x; r.p = nz(cur.p, cur.x); end
				8'h98: begin r.a = cur.y; r.p = nz(cur.p, cur.y); end
				8'h9A: r.sp = cur.x;
				8'hE8: begin r.x = cur.x + 8'd1; r.p = nz(cur.p, r.x); end
				8'hC8: begin r.y = cur.y + 8'd1; r.p = nz(cur.p, r.y); end
				8'hCA: begin r.x = cur.x - 8'd1; r.p = nz(cur.p, r.x); end
				8'h88: begin r.y = cur.y - 8'd1; r.p = nz(cur.p, r.y); end
				8'h04, 8'h44, 8'h64, 8'h0C, 8'h14, 8'h34, 8'h54, 8'h74, 8'hD4, 8'hF4,
				8'h1A, 8'h3A, 8'h5A, 8'h7A, 8'hDA, 8'hFA, 8'hEA,
				8'h1C, 8'h3C, 8'h5C, 8'h7C, 8'hDC, 8'hFC,
				8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2: begin
				end
				default: begin
					res.bad = 1'b1;
					r.pc = cur.pc;
				end
			endcase
			if (br && take) begin
				r.pc = next_pc + {{8{operand[7]}}, operand};
			end
		end
		// The carry-in is the carry as it stands after any shift of this item.
		sum = {1'b0, r.a} + {1'b0, adc_m} + {8'h00, r.p[FLAG_C]};
		if (do_adc) begin
			r.p[FLAG_C] = sum[8];
			r.p[FLAG_V] = (r.a[7] ^ sum[7]) & (adc_m[7] ^ sum[7]);
			r.a = sum[7:0];
			r.p = nz(r.p, sum[7:0]);
		end
		res.regs = r;
	end

endmodule

// ===== rtl/mos_out_seq.sv =====
// ----------------------------------------------------------------------------
// mos_out_seq: result sequencer
// Holds one executed item and hands out its writes and final register result.
// ----------------------------------------------------------------------------
module mos_out_seq import mos_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  exec_t       item,
	output logic        busy,
	output logic        done,
	input  logic        ready,
	output logic        write_valid,
	output logic [15:0] write_addr,
	output logic [7:0]  write_data,
	output logic [7:0]  out_a,
	output logic [7:0]  out_x,
	output logic [7:0]  out_y,
	output logic [7:0]  out_sp,
	output logic [7:0]  out_status,
	output logic [15:0] out_pc,
	output logic        bad_opcode,
	output logic        last_of_run
);

	logic        full_q;
	logic [1:0]  idx_q;
	exec_t       item_q;
	logic        is_last;

	assign busy    = full_q;
	assign is_last = (idx_q == item_q.nwr);
	assign done    = full_q && ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (full_q && ready) begin
			if (is_last) full_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) item_q <= item;
	end

	always_comb begin
		write_valid = !is_last;
		write_addr  = '0;
		write_data  = '0;
		case (idx_q)
			2'd0: begin write_addr = item_q.waddr[0]; write_data = item_q.wdata[0]; end
			2'd1: begin write_addr = item_q.waddr[1]; write_data = item_q.wdata[1]; end
			2'd2: begin write_addr = item_q.waddr[2]; write_data = item_q.wdata[2]; end
			default: begin end
		endcase
		if (is_last) begin
			write_addr = '0;
			write_data = '0;
		end
		out_a       = is_last ? item_q.regs.a  : 8'h00;
		out_x       = is_last ? item_q.regs.x  : 8'h00;
		out_y       = is_last ? item_q.regs.y  : 8'h00;
		out_sp      = is_last ? item_q.regs.sp : 8'h00;
		out_status  = is_last ? item_q.regs.p  : 8'h00;
		out_pc      = is_last ? item_q.regs.pc : 16'h0000;
		bad_opcode  = is_last && item_q.bad;
		last_of_run = is_last;
	end

endmodule
